// ===== rtl/lci_pkg.sv =====
// Shared types, constants and helper functions for the cubic Lagrange interpolator.
// Used by every module under rtl; depends on nothing else.
package lci_pkg;

  localparam int DATA_W  = 32;
  localparam int IDX_W   = 4;
  localparam int NUM_W   = 128;
  localparam int DEN_W   = 96;
  localparam int SUM_W   = 130;
  localparam int NODES   = 4;

  localparam logic [IDX_W-1:0] REG_X0 = 4'd0;
  localparam logic [IDX_W-1:0] REG_X1 = 4'd1;
  localparam logic [IDX_W-1:0] REG_X2 = 4'd2;
  localparam logic [IDX_W-1:0] REG_X3 = 4'd3;
  localparam logic [IDX_W-1:0] REG_F0 = 4'd4;
  localparam logic [IDX_W-1:0] REG_F1 = 4'd5;
  localparam logic [IDX_W-1:0] REG_F2 = 4'd6;
  localparam logic [IDX_W-1:0] REG_F3 = 4'd7;

  localparam logic [NODES-1:0][DATA_W-1:0] X_RESET = {32'd196608, 32'd131072, 32'd65536, 32'd0};

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DUP = 2'd1,
    ST_SAT = 2'd2
  } status_t;

  // Denominators of the four basis weights, derived from the node abscissae.
  typedef struct packed {
    logic [NODES-1:0][DEN_W-1:0] den;
    logic [NODES-1:0]            den_neg;
    logic                        dup;
  } coef_t;

  // Sign in the top bit, magnitude of a - b below it.
  function automatic logic [DATA_W:0] lci_diff(input logic signed [DATA_W-1:0] a,
                                               input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] d;
    logic        [DATA_W:0] nd;
    d  = (DATA_W+1)'(a) - (DATA_W+1)'(b);
    nd = -d;
    return {d[DATA_W], d[DATA_W] ? nd[DATA_W-1:0] : d[DATA_W-1:0]};
  endfunction

  // The k-th node other than node i.
  function automatic logic [1:0] lci_other(input logic [1:0] i, input logic [1:0] k);
    return (k < i) ? k : k + 2'd1;
  endfunction

endpackage

// ===== rtl/lagrange_cubic_interpolator_core.sv =====
// Cubic Lagrange interpolator: one query accepted per cycle, busy is low outside reset.
// A query passes the input registers, then the product stages and the 128-stage divider
// of each lane, then the summing stages, to the result.
// Synchronous reset clears all valid bits and restores the node registers to 0, 65536, 131072
// and 196608 and the values to zero; the receiver cannot stall, so results never wait.
module lagrange_cubic_interpolator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [lci_pkg::DATA_W-1:0] query_x,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lci_pkg::IDX_W-1:0]       cfg_index,
  input  logic [lci_pkg::DATA_W-1:0]      cfg_data,
  output logic                            done,
  output logic signed [lci_pkg::DATA_W-1:0] interp_value,
  output logic [1:0]                      status
);
  import lci_pkg::*;

  localparam int LATENCY = 139;

  logic [NODES-1:0][DATA_W-1:0] node_x, value_f;
  logic                         accept;
  logic [DATA_W-1:0]            q_reg;
  logic                         v_q, v_d;
  logic [NODES-1:0][DATA_W-1:0] qm;
  logic [NODES-1:0]             qs;
  coef_t                        coef;

  logic [NODES-1:0]             lane_v, div_v, lane_n, div_n, term_neg;
  logic [NODES-1:0][NUM_W-1:0]  lane_p, div_q;
  logic [DATA_W-1:0]            sum_value;
  status_t                      sum_status;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_x  <= X_RESET;
      value_f <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X0:  node_x[0]  <= cfg_data;
        REG_X1:  node_x[1]  <= cfg_data;
        REG_X2:  node_x[2]  <= cfg_data;
        REG_X3:  node_x[3]  <= cfg_data;
        REG_F0:  value_f[0] <= cfg_data;
        REG_F1:  value_f[1] <= cfg_data;
        REG_F2:  value_f[2] <= cfg_data;
        REG_F3:  value_f[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
      v_d <= 1'b0;
    end else begin
      v_q <= accept;
      v_d <= v_q;
    end
  end

  always_ff @(posedge clk) begin
    logic [DATA_W:0] r;
    q_reg <= query_x;
    for (int j = 0; j < NODES; j++) begin
      r     = lci_diff(q_reg, node_x[j]);
      qm[j] <= r[DATA_W-1:0];
      qs[j] <= r[DATA_W];
    end
  end

  lci_coef u_coef (
    .clk    (clk),
    .node_x (node_x),
    .coef   (coef)
  );

  for (genvar i = 0; i < NODES; i++) begin : g_lane
    localparam logic [1:0] O0 = lci_other(2'(i), 2'd0);
    localparam logic [1:0] O1 = lci_other(2'(i), 2'd1);
    localparam logic [1:0] O2 = lci_other(2'(i), 2'd2);
    logic [DATA_W-1:0] fmag;
    logic [DATA_W:0]   fd;

    assign fd   = lci_diff(value_f[i], '0);
    assign fmag = fd[DATA_W-1:0];

    lci_num u_num (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v_d),
      .fmag      (fmag),
      .m         ({qm[O2], qm[O1], qm[O0]}),
      .neg_in    (fd[DATA_W] ^ qs[O0] ^ qs[O1] ^ qs[O2]),
      .out_valid (lane_v[i]),
      .prod      (lane_p[i]),
      .neg_out   (lane_n[i])
    );

    lci_div u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (lane_v[i]),
      .num       (lane_p[i]),
      .den       (coef.den[i]),
      .neg_in    (lane_n[i]),
      .out_valid (div_v[i]),
      .quo       (div_q[i]),
      .neg_out   (div_n[i])
    );

    assign term_neg[i] = div_n[i] ^ coef.den_neg[i];
  end

  lci_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_v[0]),
    .quo       (div_q),
    .neg       (term_neg),
    .dup       (coef.dup),
    .out_valid (done),
    .value     (sum_value),
    .status    (sum_status)
  );

  assign interp_value = sum_value;
  assign status       = sum_status;

`ifndef SYNTHESIS
  // All four lanes run in lock step.
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (div_v[0] == div_v[1]) && (div_v[0] == div_v[2]) && (div_v[0] == div_v[3]))
    else $error("divider lanes out of step");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted transaction produced no result at the expected cycle");

  a_dup_zero: assert property (@(posedge clk) disable iff (rst)
    done && coef.dup |-> status == ST_DUP && interp_value == '0)
    else $error("duplicate nodes did not give a zero result");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_SAT |-> interp_value == 32'sh7FFF_FFFF ||
                                 interp_value == 32'sh8000_0000)
    else $error("saturated result is not a limit value");
`endif

endmodule

// ===== rtl/lci_coef.sv =====
// Basis weight denominators and the duplicate node flag, computed from the node registers.
// Free-running four-stage product pipeline; depends on lci_pkg.
module lci_coef (
  input  logic                                          clk,
  input  logic [lci_pkg::NODES-1:0][lci_pkg::DATA_W-1:0] node_x,
  output lci_pkg::coef_t                                coef
);
  import lci_pkg::*;

  logic [NODES-1:0][2:0][DATA_W-1:0] dm_c;
  logic [NODES-1:0]                  sg_c;
  logic                              dup_c;

  logic [NODES-1:0][2:0][DATA_W-1:0] dm1;
  logic [NODES-1:0]                  sg1, sg2, sg3, sg4;
  logic                              dup1, dup2, dup3, dup4;
  logic [NODES-1:0][63:0]            a2, lo3, hi3;
  logic [NODES-1:0][DATA_W-1:0]      m2;
  logic [NODES-1:0][DEN_W-1:0]       den4;

  always_comb begin
    logic [DATA_W:0] r;
    dup_c = 1'b0;
    dm_c  = '0;
    sg_c  = '0;
    for (int i = 0; i < NODES; i++) begin
      for (int k = 0; k < 3; k++) begin
        r = lci_diff(node_x[i], node_x[lci_other(2'(i), 2'(k))]);
        dm_c[i][k] = r[DATA_W-1:0];
        sg_c[i]    = sg_c[i] ^ r[DATA_W];
      end
      for (int j = i + 1; j < NODES; j++) begin
        if (node_x[i] == node_x[j]) dup_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dm1  <= dm_c;
    sg1  <= sg_c;
    dup1 <= dup_c;
    for (int i = 0; i < NODES; i++) begin
      a2[i]   <= 64'(dm1[i][0]) * 64'(dm1[i][1]);
      m2[i]   <= dm1[i][2];
      lo3[i]  <= 64'(a2[i][31:0]) * 64'(m2[i]);
      hi3[i]  <= 64'(a2[i][63:32]) * 64'(m2[i]);
      den4[i] <= 96'(lo3[i]) + {hi3[i], 32'b0};
    end
    sg2  <= sg1;
    sg3  <= sg2;
    sg4  <= sg3;
    dup2 <= dup1;
    dup3 <= dup2;
    dup4 <= dup3;
  end

  assign coef.den     = den4;
  assign coef.den_neg = sg4;
  assign coef.dup     = dup4;

endmodule

// ===== rtl/lci_num.sv =====
// One numerator lane: |f_i| times three query differences, as 32 by 32 partial products.
// Five register stages; depends on lci_pkg.
module lci_num (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [lci_pkg::DATA_W-1:0]       fmag,
  input  logic [2:0][lci_pkg::DATA_W-1:0]  m,
  input  logic                             neg_in,
  output logic                             out_valid,
  output logic [lci_pkg::NUM_W-1:0]        prod,
  output logic                             neg_out
);
  import lci_pkg::*;

  logic [4:0]        v;
  logic [63:0]       p1, lo2, hi2, c0, c1, c2;
  logic [DATA_W-1:0] mb1, mc1, mc2, mc3;
  logic [95:0]       p2;
  logic [4:0]        n;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    p1   <= 64'(fmag) * 64'(m[0]);
    mb1  <= m[1];
    mc1  <= m[2];
    lo2  <= 64'(p1[31:0]) * 64'(mb1);
    hi2  <= 64'(p1[63:32]) * 64'(mb1);
    mc2  <= mc1;
    p2   <= 96'(lo2) + {hi2, 32'b0};
    mc3  <= mc2;
    c0   <= 64'(p2[31:0]) * 64'(mc3);
    c1   <= 64'(p2[63:32]) * 64'(mc3);
    c2   <= 64'(p2[95:64]) * 64'(mc3);
    prod <= 128'(c0) + {32'b0, c1, 32'b0} + {c2, 64'b0};
    n    <= {n[3:0], neg_in};
  end

  assign out_valid = v[4];
  assign neg_out   = n[4];

endmodule

// ===== rtl/lci_div.sv =====
// Pipelined restoring divider for one lane, one quotient bit per stage. While items
// are in flight, the user must hold the node-register divisor steady; not enforced.
module lci_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [lci_pkg::NUM_W-1:0]   num,
  input  logic [lci_pkg::DEN_W-1:0]   den,
  input  logic                        neg_in,
  output logic                        out_valid,
  output logic [lci_pkg::NUM_W-1:0]   quo,
  output logic                        neg_out
);
  import lci_pkg::*;

  logic [DEN_W-1:0] rem [NUM_W];
  logic [NUM_W-1:0] nq  [NUM_W];
  logic [NUM_W-1:0] v;
  logic [NUM_W-1:0] sg;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rp;
    logic [NUM_W-1:0] np;
    logic             vp, sp, ge;
    logic [DEN_W:0]   trial, diff;

    if (k == 0) begin : g_first
      assign rp = '0;
      assign np = num;
      assign vp = in_valid;
      assign sp = neg_in;
    end else begin : g_next
      assign rp = rem[k-1];
      assign np = nq[k-1];
      assign vp = v[k-1];
      assign sp = sg[k-1];
    end

    // The partial remainder stays below the divisor, so the difference fits.
    assign trial = {rp, np[NUM_W-1]};
    assign diff  = trial - {1'b0, den};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      rem[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nq[k]  <= {np[NUM_W-2:0], ge};
      sg[k]  <= sp;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else begin
        v[k] <= vp;
      end
    end
  end

  assign out_valid = v[NUM_W-1];
  assign quo       = nq[NUM_W-1];
  assign neg_out   = sg[NUM_W-1];

endmodule

// ===== rtl/lci_sum.sv =====
// Signs the four truncated terms, sums them over two adder stages and saturates.
// Duplicate nodes give zero. Four register stages; depends on lci_pkg.
module lci_sum (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  input  logic [lci_pkg::NODES-1:0][lci_pkg::NUM_W-1:0] quo,
  input  logic [lci_pkg::NODES-1:0]                    neg,
  input  logic                                         dup,
  output logic                                         out_valid,
  output logic [lci_pkg::DATA_W-1:0]                   value,
  output lci_pkg::status_t                             status
);
  import lci_pkg::*;

  logic [2:0]                   v;
  logic [NODES-1:0][SUM_W-1:0]  t;
  logic [SUM_W-1:0]             s01, s23, s;
  logic                         fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      v         <= {v[1:0], in_valid};
      out_valid <= v[2];
    end
  end

  assign fits = (&s[SUM_W-1:DATA_W-1]) | ~(|s[SUM_W-1:DATA_W-1]);

  always_ff @(posedge clk) begin
    for (int i = 0; i < NODES; i++) begin
      t[i] <= neg[i] ? SUM_W'(0) - {2'b0, quo[i]} : {2'b0, quo[i]};
    end
    s01 <= t[0] + t[1];
    s23 <= t[2] + t[3];
    s   <= s01 + s23;
    if (dup) begin
      value  <= '0;
      status <= ST_DUP;
    end else if (fits) begin
      value  <= s[DATA_W-1:0];
      status <= ST_OK;
    end else begin
      value  <= s[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      status <= ST_SAT;
    end
  end

endmodule
